// ----- hw/rtl/fue_pkg.sv -----
// ----------------------------------------------------------------------------
// fue_pkg
// Shared types, codes and character helpers for the form-urlencode encoder.
// ----------------------------------------------------------------------------
package fue_pkg;

	localparam int FUE_QUEUE_DEPTH = 2;

	localparam logic [1:0] KIND_PASS = 2'd0;
	localparam logic [1:0] KIND_CRLF = 2'd1;
	localparam logic [1:0] KIND_PCT  = 2'd2;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} desc_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'd0, nib};
		end else begin
			c = 8'h37 + {4'd0, nib};
		end
		return c;
	endfunction

	// %0D%0A
	function automatic logic [7:0] crlf_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0: c = CH_PCT;
			3'd1: c = 8'h30;
			3'd2: c = 8'h44;
			3'd3: c = CH_PCT;
			3'd4: c = 8'h30;
			3'd5: c = 8'h41;
			default: c = CH_PCT;
		endcase
		return c;
	endfunction

endpackage

// ----- hw/rtl/fue_front.sv -----
// ----------------------------------------------------------------------------
// fue_front
// Accepts input bytes, classifies them and registers a descriptor for the
// queue. Carriage returns are consumed without a descriptor.
// ----------------------------------------------------------------------------
module fue_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_byte,
	output logic           fq_valid,
	input  logic           fq_ready,
	output fue_pkg::desc_t fq_desc
);
	import fue_pkg::*;

	logic  valid_s1;
	desc_t desc_s1;
	desc_t desc_d;
	logic  is_pass;
	logic  is_drop;
	logic  accept;

	always_comb begin
		is_pass = ((in_byte >= 8'h41) && (in_byte <= 8'h5A)) ||
			((in_byte >= 8'h61) && (in_byte <= 8'h7A)) ||
			((in_byte >= 8'h30) && (in_byte <= 8'h39)) ||
			(in_byte == 8'h24) || (in_byte == 8'h2D) || (in_byte == 8'h2E) ||
			(in_byte == 8'h5F) || (in_byte == 8'h21) || (in_byte == 8'h2A) ||
			(in_byte == 8'h28) || (in_byte == 8'h29) || (in_byte == 8'h2C);
		is_drop = (in_byte == CH_CR);
		desc_d.data = in_byte;
		if (is_pass) begin
			desc_d.kind = KIND_PASS;
		end else if (in_byte == CH_SPACE) begin
			desc_d.kind = KIND_PASS;
			desc_d.data = CH_PLUS;
		end else if (in_byte == CH_LF) begin
			desc_d.kind = KIND_CRLF;
		end else begin
			desc_d.kind = KIND_PCT;
		end
	end

	assign in_ready = !valid_s1 || fq_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= !is_drop;
		end else if (fq_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc_d;
		end
	end

	assign fq_valid = valid_s1;
	assign fq_desc  = desc_s1;

endmodule

// ----- hw/rtl/fue_queue.sv -----
// ----------------------------------------------------------------------------
// fue_queue
// Short descriptor queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module fue_queue #(
	parameter int Depth = fue_pkg::FUE_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  fue_pkg::desc_t wr_desc,
	output logic           rd_valid,
	input  logic           rd_ready,
	output fue_pkg::desc_t rd_desc
);
	import fue_pkg::*;

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

	desc_t          mem_q [Depth];
	logic [AW-1:0]  wptr_q;
	logic [AW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;
	logic           push;
	logic           pop;

	assign wr_ready = (count_q != FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_desc  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_desc;
		end
	end

endmodule

// ----- hw/rtl/fue_back.sv -----
// ----------------------------------------------------------------------------
// fue_back
// Output sequencer: expands one descriptor into one, three or six bytes and
// drives the registered output beat.
// ----------------------------------------------------------------------------
module fue_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_valid,
	output logic           rd_ready,
	input  fue_pkg::desc_t rd_desc,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           run_last
);
	import fue_pkg::*;

	logic       cur_valid_q;
	desc_t      cur_q;
	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic [7:0] gen_byte;
	logic       gen_last;
	logic       out_free;
	logic       emit;

	always_comb begin
		case (cur_q.kind)
			KIND_PASS: begin
				gen_byte = cur_q.data;
				gen_last = 1'b1;
			end
			KIND_CRLF: begin
				gen_byte = crlf_char(idx_q);
				gen_last = (idx_q == 3'd5);
			end
			KIND_PCT: begin
				case (idx_q)
					3'd0:    gen_byte = CH_PCT;
					3'd1:    gen_byte = hex_char(cur_q.data[7:4]);
					default: gen_byte = hex_char(cur_q.data[3:0]);
				endcase
				gen_last = (idx_q == 3'd2);
			end
			default: begin
				gen_byte = cur_q.data;
				gen_last = 1'b1;
			end
		endcase
	end

	assign out_free = !out_valid_q || out_ready;
	assign emit     = cur_valid_q && out_free;
	assign rd_ready = !cur_valid_q || (emit && gen_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_ready) begin
				cur_valid_q <= rd_valid;
				idx_q       <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 3'd1;
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_ready && rd_valid) begin
			cur_q <= rd_desc;
		end
		if (emit) begin
			out_byte_q <= gen_byte;
			run_last_q <= gen_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

endmodule

// ----- hw/rtl/form_urlencode_byte_encoder_top.sv -----
// ----------------------------------------------------------------------------
// form_urlencode_byte_encoder_top
// Form-urlencoded encoder for a stream of Latin-1 bytes.
// ----------------------------------------------------------------------------
// Each input byte gives one output beat (letters, digits, the safe set and
// space as '+'), three beats ('%' and two uppercase hex digits, NUL included),
// six beats for line feed (%0D%0A) or none for carriage return; run_last
// marks the final beat of each byte. Unless out_ready stalls, bytes that map
// to one beat flow at one per cycle and the output sequencer emits one beat
// per cycle, so an expanding byte occupies it for three or six beats while
// the descriptor queue (QueueDepth entries) takes input until it is full.
// Output beats are registered. Reset has no effect on the encoding itself.
module form_urlencode_byte_encoder_top #(
	parameter int QueueDepth = fue_pkg::FUE_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last
);
	import fue_pkg::*;

	logic  fq_valid;
	logic  fq_ready;
	desc_t fq_desc;
	logic  bq_valid;
	logic  bq_ready;
	desc_t bq_desc;

	fue_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.fq_valid (fq_valid),
		.fq_ready (fq_ready),
		.fq_desc  (fq_desc)
	);

	fue_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_desc  (fq_desc),
		.rd_valid (bq_valid),
		.rd_ready (bq_ready),
		.rd_desc  (bq_desc)
	);

	fue_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_valid  (bq_valid),
		.rd_ready  (bq_ready),
		.rd_desc   (bq_desc),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule

// ----- hw/rtl/fue_checker.sv -----
// ----------------------------------------------------------------------------
// fue_checker
// Port-level checks on the encoder output, bound to the top level.
// ----------------------------------------------------------------------------
module fue_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last
);
	import fue_pkg::*;

	logic hex_digit;
	assign hex_digit = ((out_byte >= 8'h30) && (out_byte <= 8'h39)) ||
		((out_byte >= 8'h41) && (out_byte <= 8'h46));

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("output beat changed while stalled");

	a_mid_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> (out_byte == CH_PCT) || hex_digit)
		else $error("non-final beat is not part of an escape");

	a_last_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_last |-> (out_byte != CH_PCT) && (out_byte != CH_SPACE) &&
			(out_byte != CH_CR) && (out_byte != CH_LF))
		else $error("final beat carries an unencoded character");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind form_urlencode_byte_encoder_top fue_checker u_fue_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.run_last  (run_last)
);
